@@ hdl/improv_serial_deframer_assert.svh @@
// Assertion macros used by the checker of the serial deframer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef IMPROV_SERIAL_DEFRAMER_ASSERT_SVH
`define IMPROV_SERIAL_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ISD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define ISD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

// Condition that must hold in the cycle after reset is applied.
`define ISD_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("deframer reset check failed");

`endif

@@ hdl/isd_pkg.sv @@
package isd_pkg;

  // Field widths fixed by the frame format.
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;

  // Default payload capacity.
  localparam int MAX_PAYLOAD_DEF = 64;

  // Frame layout.
  localparam int HDR_LEN         = 6;
  localparam int VERSION_POS     = 6;
  localparam int TYPE_POS        = 7;
  localparam int LENGTH_BYTE_POS = 8;
  localparam int LENGTH_POS      = 9;
  localparam int FRAME_OVERHEAD  = 10;
  localparam logic [CNT_W-1:0] TARGET_UNREACHABLE = 7'd127;

  // Reset value of the expected version register.
  localparam logic [BYTE_W-1:0] EXP_VERSION_RST = 8'd1;

  // Command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Header characters "IMPROV".
  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [2:0] pos);
    logic [BYTE_W-1:0] val;
    case (pos)
      3'd0:    val = 8'h49;
      3'd1:    val = 8'h4D;
      3'd2:    val = 8'h50;
      3'd3:    val = 8'h52;
      3'd4:    val = 8'h4F;
      3'd5:    val = 8'h56;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Work handed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_INVALID,
    CMD_EMPTY,
    CMD_PAYLOAD
  } cmd_kind_t;

  // data is the payload byte for a write and the packet type for an empty or payload frame;
  // arg is the store index for a write and the payload length for an emit.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  arg;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SHOW
  } back_state_t;

endpackage

@@ hdl/isd_cmd_queue.sv @@
module isd_cmd_queue import isd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  cmd_t        push_cmd,
  input  logic        pop,
  output cmd_t        head_cmd,
  output queue_stat_t stat
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  // Status and head of the queue.
  assign stat.full  = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  // Pointer and fill updates.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ hdl/isd_front.sv @@
module isd_front import isd_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  input  queue_stat_t       q_stat,
  output logic              push,
  output cmd_t              push_cmd
);

  localparam logic [CNT_W-1:0] FRAME_BUFFER = CNT_W'(FRAME_OVERHEAD + MAX_PAYLOAD);

  logic [BYTE_W-1:0] exp_ver_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  target_r, target_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] version_r, version_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] length_r, length_nxt;
  logic              accept;
  logic              is_start;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  pay_idx;
  logic              frame_ok;

  // Every byte causes at most one command, so a free queue slot is enough.
  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign is_start = (in_rx_byte == hdr_byte(3'd0));
  assign pos_inc  = count_r + 1'b1;
  assign pay_idx  = count_r - CNT_W'(LENGTH_POS);
  assign frame_ok = (version_r == exp_ver_r) && (sum_r == in_rx_byte);

  // Classify the incoming byte against the frame position.
  always_comb begin
    count_nxt   = count_r;
    target_nxt  = target_r;
    sum_nxt     = sum_r;
    version_nxt = version_r;
    type_nxt    = type_r;
    length_nxt  = length_r;
    push        = 1'b0;
    push_cmd    = '{kind: CMD_WRITE, data: in_rx_byte, arg: pay_idx};
    if (accept) begin
      if (count_r == '0 || (count_r < CNT_W'(HDR_LEN) &&
                            in_rx_byte != hdr_byte(count_r[2:0]))) begin
        // Hunt for the header, keeping a byte that can open one.
        count_nxt  = is_start ? CNT_W'(1) : '0;
        sum_nxt    = is_start ? in_rx_byte : '0;
        target_nxt = '0;
      end else if (count_r < CNT_W'(HDR_LEN)) begin
        count_nxt = pos_inc;
        sum_nxt   = sum_r + in_rx_byte;
      end else if (count_r >= FRAME_BUFFER) begin
        // Buffer full: report and restart with this byte.
        count_nxt     = is_start ? CNT_W'(1) : '0;
        sum_nxt       = is_start ? in_rx_byte : '0;
        target_nxt    = '0;
        push          = 1'b1;
        push_cmd.kind = CMD_INVALID;
        push_cmd.data = '0;
        push_cmd.arg  = '0;
      end else begin
        count_nxt = pos_inc;
        if (count_r == CNT_W'(VERSION_POS)) begin
          version_nxt = in_rx_byte;
        end else if (count_r == CNT_W'(TYPE_POS)) begin
          type_nxt = in_rx_byte;
        end else if (count_r == CNT_W'(LENGTH_BYTE_POS)) begin
          length_nxt = in_rx_byte;
          if (in_rx_byte <= BYTE_W'(MAX_PAYLOAD)) begin
            target_nxt = CNT_W'(FRAME_OVERHEAD) + CNT_W'(in_rx_byte);
          end else begin
            target_nxt = TARGET_UNREACHABLE;
          end
        end
        if (target_nxt == '0 || pos_inc < target_nxt) begin
          sum_nxt = sum_r + in_rx_byte;
          // Payload bytes go to the store in the back part.
          if (count_r >= CNT_W'(LENGTH_POS) && pay_idx < CNT_W'(MAX_PAYLOAD)) begin
            push = 1'b1;
          end
        end else begin
          // Checksum byte closes the frame.
          count_nxt     = '0;
          target_nxt    = '0;
          sum_nxt       = '0;
          push          = 1'b1;
          push_cmd.data = type_r;
          push_cmd.arg  = length_r[LEN_W-1:0];
          if (!frame_ok) begin
            push_cmd.kind = CMD_INVALID;
            push_cmd.data = '0;
            push_cmd.arg  = '0;
          end else if (length_r == '0) begin
            push_cmd.kind = CMD_EMPTY;
          end else begin
            push_cmd.kind = CMD_PAYLOAD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r <= EXP_VERSION_RST;
      count_r   <= '0;
      target_r  <= '0;
      sum_r     <= '0;
      version_r <= '0;
      type_r    <= '0;
      length_r  <= '0;
    end else begin
      if (cfg_we) begin
        exp_ver_r <= cfg_wdata;
      end
      count_r   <= count_nxt;
      target_r  <= target_nxt;
      sum_r     <= sum_nxt;
      version_r <= version_nxt;
      type_r    <= type_nxt;
      length_r  <= length_nxt;
    end
  end

endmodule

@@ hdl/isd_back.sv @@
module isd_back import isd_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  queue_stat_t       q_stat,
  input  cmd_t              head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_status,
  output logic [BYTE_W-1:0] out_packet_type,
  output logic [LEN_W-1:0]  out_payload_length,
  output logic              out_has_data,
  output logic [BYTE_W-1:0] out_data_byte,
  output logic [IDX_W-1:0]  out_data_index,
  output logic              out_last
);

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [BYTE_W-1:0] store_mem [MAX_PAYLOAD];
  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [BYTE_W-1:0] rd_data_r;
  logic              is_payload;
  logic              at_end;

  assign is_payload = (cmd_r.kind == CMD_PAYLOAD);
  assign at_end     = (LEN_W'(idx_r) + LEN_W'(1) == cmd_r.arg);

  // Next state: pop commands while idle, walk the payload on an emit.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty && head_cmd.kind != CMD_WRITE) begin
          cmd_nxt = head_cmd;
          idx_nxt = '0;
          state_nxt = (head_cmd.kind == CMD_PAYLOAD) ? BK_READ : BK_SHOW;
        end
      end
      BK_READ: begin
        state_nxt = BK_SHOW;
      end
      BK_SHOW: begin
        if (out_ready) begin
          if (is_payload && !at_end) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = BK_READ;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Outputs of the result stage and the queue pop.
  always_comb begin
    pop                = (state_r == BK_IDLE) && !q_stat.empty;
    out_valid          = (state_r == BK_SHOW);
    out_status         = (cmd_r.kind == CMD_INVALID);
    out_packet_type    = out_status ? '0 : cmd_r.data;
    out_payload_length = is_payload ? cmd_r.arg : '0;
    out_has_data       = is_payload;
    out_data_byte      = is_payload ? rd_data_r : '0;
    out_data_index     = is_payload ? IDX_W'(idx_r) : '0;
    out_last           = !is_payload || at_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
  end

  // Payload store: written from write commands, read one entry per result.
  always_ff @(posedge clk) begin
    if (pop && head_cmd.kind == CMD_WRITE) begin
      store_mem[head_cmd.arg[ADDR_W-1:0]] <= head_cmd.data;
    end
    if (state_r == BK_READ) begin
      rd_data_r <= store_mem[idx_r];
    end
  end

endmodule

@@ hdl/improv_serial_deframer.sv @@
// Serial frame parser for "IMPROV" packets. Bytes enter on in_* one per
// transfer; the front part takes one byte per cycle as long as its four-entry
// command queue has room, tracking header, version, type, length and checksum.
// Payload bytes are written into a payload store in the back part. At the
// frame's checksum byte the back part emits one result per payload byte (a
// registered store read in BK_READ, then the result shown in BK_SHOW until
// out_ready), or a single result for an empty or invalid frame. The queue
// lets input keep flowing while results drain. The expected version is
// written through cfg_we and cfg_wdata; the user must do so only while the
// block is idle, as the block does not enforce it. It resets to 1.
module improv_serial_deframer import isd_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_status,
  output logic [BYTE_W-1:0] out_packet_type,
  output logic [LEN_W-1:0]  out_payload_length,
  output logic              out_has_data,
  output logic [BYTE_W-1:0] out_data_byte,
  output logic [IDX_W-1:0]  out_data_index,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata
);

  queue_stat_t q_stat;
  logic        push, pop;
  cmd_t        push_cmd, head_cmd;

  // Byte classification and frame tracking.
  isd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_rx_byte(in_rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Command queue between the two parts.
  isd_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head_cmd(head_cmd),
    .stat    (q_stat)
  );

  // Payload store and result sequencing.
  isd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .head_cmd          (head_cmd),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_packet_type   (out_packet_type),
    .out_payload_length(out_payload_length),
    .out_has_data      (out_has_data),
    .out_data_byte     (out_data_byte),
    .out_data_index    (out_data_index),
    .out_last          (out_last)
  );

endmodule

@@ hdl/isd_checker.sv @@
`include "improv_serial_deframer_assert.svh"

module isd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_status,
  input logic [7:0] out_packet_type,
  input logic [6:0] out_payload_length,
  input logic       out_has_data,
  input logic [7:0] out_data_byte,
  input logic [5:0] out_data_index,
  input logic       out_last
);

  // A stalled result holds until its transfer.
  `ISD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data_byte) && $stable(out_data_index) && $stable(out_last) && $stable(out_status))

  // An invalid frame is reported as one bare, final result.
  `ISD_ASSERT_NOW(a_invalid_shape, out_valid && out_status, !out_has_data && out_last && out_packet_type == 8'd0 && out_payload_length == 7'd0)

  // A payload byte lies inside its packet; the final one closes it.
  `ISD_ASSERT_NOW(a_index_range, out_valid && out_has_data, ({1'b0, out_data_index} < out_payload_length) && (out_last == ({1'b0, out_data_index} + 7'd1 == out_payload_length)))

  // No result is shown right after reset.
  `ISD_ASSERT_AFTER_RESET(a_reset_quiet, !out_valid)

endmodule

bind improv_serial_deframer isd_checker u_isd_checker (.*);
